[hw/rtl/dmc_pkg.sv]
`timescale 1ns / 1ps

package dmc_pkg;

    localparam int NUM_LINES  = 2048;
    localparam int IDX_W      = $clog2(NUM_LINES);
    localparam int OFFS_W     = 3;
    localparam int ADDR_W     = 64;
    localparam int DATA_W     = 64;
    localparam int WORD_W     = 32;
    localparam int BYTES      = DATA_W / 8;
    localparam int SIZE_W     = 4;
    localparam int TAG_W      = ADDR_W - OFFS_W - IDX_W;
    localparam int S_TDATA_W  = ((ADDR_W + DATA_W + SIZE_W + 7) / 8) * 8;
    localparam int PAD_W      = S_TDATA_W - ADDR_W - DATA_W - SIZE_W;

    typedef logic [IDX_W-1:0] line_idx_t;
    typedef logic [TAG_W-1:0] line_tag_t;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_FILL   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // request to the tag array: lookup read or fill write
    typedef struct packed {
        logic      rd_en;
        logic      fill_en;
        line_idx_t idx;
        line_tag_t tag;
    } tag_req_t;

    // request to the data array: lookup read or byte-enabled write
    typedef struct packed {
        logic              rd_en;
        logic [BYTES-1:0]  byte_en;
        line_idx_t         idx;
        logic [DATA_W-1:0] wdata;
    } data_req_t;

endpackage

[hw/rtl/dmc_tag_mem.sv]
`timescale 1ns / 1ps

module dmc_tag_mem (
    input  logic               aclk,
    input  logic               aresetn,
    input  dmc_pkg::tag_req_t  req,
    output logic               busy,
    output logic               rd_valid,
    output dmc_pkg::line_tag_t rd_tag
);

    // each entry: valid mark above the tag
    logic [dmc_pkg::TAG_W:0] mem [dmc_pkg::NUM_LINES];

    logic               clr_busy_reg;
    logic               clr_busy_next;
    dmc_pkg::line_idx_t clr_idx_reg;
    dmc_pkg::line_idx_t clr_idx_next;
    logic [dmc_pkg::TAG_W:0] rd_entry_reg;

    // sweep every entry once after reset to drop the valid marks
    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_idx_next  = clr_idx_reg;
        if (clr_busy_reg) begin
            clr_idx_next = clr_idx_reg + dmc_pkg::line_idx_t'(1);
            if (clr_idx_reg == dmc_pkg::line_idx_t'(dmc_pkg::NUM_LINES - 1)) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_idx_reg  <= clr_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_idx_reg] <= '0;
        end else if (req.fill_en) begin
            mem[req.idx] <= {1'b1, req.tag};
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_entry_reg <= mem[req.idx];
        end
    end

    assign busy     = clr_busy_reg;
    assign rd_valid = rd_entry_reg[dmc_pkg::TAG_W];
    assign rd_tag   = rd_entry_reg[dmc_pkg::TAG_W-1:0];

endmodule

[hw/rtl/dmc_data_mem.sv]
`timescale 1ns / 1ps

module dmc_data_mem (
    input  logic                        aclk,
    input  dmc_pkg::data_req_t          req,
    output logic [dmc_pkg::DATA_W-1:0]  rd_data
);

    logic [dmc_pkg::DATA_W-1:0] mem [dmc_pkg::NUM_LINES];
    logic [dmc_pkg::DATA_W-1:0] rd_data_reg;

    // byte lanes merge in place, no read-back needed
    always_ff @(posedge aclk) begin
        for (int b = 0; b < dmc_pkg::BYTES; b++) begin
            if (req.byte_en[b]) begin
                mem[req.idx][b*8 +: 8] <= req.wdata[b*8 +: 8];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/direct_mapped_dcache.sv]
`timescale 1ns / 1ps

// Channel   Dir  Ports                       Contents
// s_        in   tvalid tready tdata tuser   request: cmd, addr, data, size_bytes
// m_        out  tvalid tready tdata tuser   result: hit, read_word
//
// One request per cycle while s_tready is high, one result per request; the result is
// valid in the cycle right after its accept edge. Each request touches each array at
// most once, at its accept edge (a lookup reads both, a fill writes both, a byte
// write the data array only), so back-to-back same-line requests need no forwarding.
// After reset a sweep clears the valid marks of all NUM_LINES (2048) entries with
// s_tready low. A stalled result holds in the output stage; a new request is taken
// whenever that stage is empty or its result leaves in the same cycle.

module direct_mapped_dcache (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [63:0] addr, [127:64] data, [131:128] size_bytes, rest zero
    input  logic [dmc_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] cmd
    input  logic [1:0]                       s_tuser,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] read_word
    output logic [dmc_pkg::WORD_W-1:0]       m_tdata,
    // [0] hit
    output logic [0:0]                       m_tuser
);

    logic [dmc_pkg::ADDR_W-1:0] req_addr;
    logic [dmc_pkg::DATA_W-1:0] req_data;
    logic [dmc_pkg::SIZE_W-1:0] req_size;
    dmc_pkg::cmd_t              req_cmd;
    logic [dmc_pkg::PAD_W-1:0]  req_pad;
    logic                       accept;
    logic                       clr_busy;
    logic [dmc_pkg::BYTES-1:0]  write_be;

    dmc_pkg::tag_req_t  tag_req;
    dmc_pkg::data_req_t data_req;
    logic               rd_valid;
    dmc_pkg::line_tag_t rd_tag;
    logic [dmc_pkg::DATA_W-1:0] rd_data;

    // output stage
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               lookup_reg;
    dmc_pkg::line_tag_t tag_reg;
    logic               word_hi_reg;
    logic               hit;

    assign req_addr = s_tdata[dmc_pkg::ADDR_W-1:0];
    assign req_data = s_tdata[dmc_pkg::ADDR_W +: dmc_pkg::DATA_W];
    assign req_size = s_tdata[dmc_pkg::ADDR_W + dmc_pkg::DATA_W +: dmc_pkg::SIZE_W];
    assign req_pad  = s_tdata[dmc_pkg::S_TDATA_W-1 -: dmc_pkg::PAD_W];
    assign req_cmd  = dmc_pkg::cmd_t'(s_tuser);

    // take a request once the sweep is done and the output stage can advance
    assign s_tready = !clr_busy && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // low size_bytes lanes; zero gives none, anything above 8 gives all
    always_comb begin
        for (int b = 0; b < dmc_pkg::BYTES; b++) begin
            write_be[b] = (dmc_pkg::SIZE_W'(b) < req_size);
        end
    end

    always_comb begin
        tag_req.rd_en    = 1'b0;
        tag_req.fill_en  = 1'b0;
        tag_req.idx      = req_addr[dmc_pkg::OFFS_W +: dmc_pkg::IDX_W];
        tag_req.tag      = req_addr[dmc_pkg::ADDR_W-1 -: dmc_pkg::TAG_W];
        data_req.rd_en   = 1'b0;
        data_req.byte_en = '0;
        data_req.idx     = req_addr[dmc_pkg::OFFS_W +: dmc_pkg::IDX_W];
        data_req.wdata   = req_data;
        if (accept) begin
            unique case (req_cmd)
                dmc_pkg::CMD_LOOKUP: begin
                    tag_req.rd_en  = 1'b1;
                    data_req.rd_en = 1'b1;
                end
                dmc_pkg::CMD_WRITE: begin
                    data_req.byte_en = write_be;
                end
                dmc_pkg::CMD_FILL: begin
                    tag_req.fill_en  = 1'b1;
                    data_req.byte_en = '1;
                end
                dmc_pkg::CMD_NONE: begin
                    // no array access; result reports a miss
                end
            endcase
        end
    end

    dmc_tag_mem u_tag_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (tag_req),
        .busy     (clr_busy),
        .rd_valid (rd_valid),
        .rd_tag   (rd_tag)
    );

    dmc_data_mem u_data_mem (
        .aclk    (aclk),
        .req     (data_req),
        .rd_data (rd_data)
    );

    // advance on accept, drop once the result is taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // hold request context beside the registered array reads
    always_ff @(posedge aclk) begin
        if (accept) begin
            lookup_reg  <= (req_cmd == dmc_pkg::CMD_LOOKUP);
            tag_reg     <= tag_req.tag;
            word_hi_reg <= req_addr[2] | (&req_pad & 1'b0);
        end
    end

    assign hit      = lookup_reg && rd_valid && (rd_tag == tag_reg);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = hit;
    assign m_tdata  = !hit        ? '0 :
                      word_hi_reg ? rd_data[dmc_pkg::DATA_W-1 -: dmc_pkg::WORD_W] :
                                    rd_data[dmc_pkg::WORD_W-1:0];

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    // one predicted result of a cache access
    typedef struct packed {
        logic                       hit;
        logic [dmc_pkg::WORD_W-1:0] word;
    } access_result_t;

    // Mirror of the cache contents; predicts the result of every accepted request
    // and checks the results that leave the block against those predictions.
    class dcache_scoreboard;
        bit                         valid_mark [dmc_pkg::NUM_LINES];
        dmc_pkg::line_tag_t         tag_store  [dmc_pkg::NUM_LINES];
        logic [dmc_pkg::DATA_W-1:0] data_store [dmc_pkg::NUM_LINES];
        access_result_t             pending_access_results [$];
        int errors, n_lookup, n_hit, n_write, n_fill, n_none, n_checked;

        function new();
            foreach (valid_mark[i]) begin
                valid_mark[i] = 1'b0;
                tag_store[i]  = '0;
                data_store[i] = '0;
            end
        endfunction

        function void predict_access(dmc_pkg::cmd_t cmd,
                                     logic [dmc_pkg::ADDR_W-1:0] addr,
                                     logic [dmc_pkg::DATA_W-1:0] wdata,
                                     logic [dmc_pkg::SIZE_W-1:0] size);
            dmc_pkg::line_idx_t idx;
            dmc_pkg::line_tag_t tag;
            access_result_t     res;
            int                 nbytes;
            idx = addr[dmc_pkg::OFFS_W +: dmc_pkg::IDX_W];
            tag = addr[dmc_pkg::ADDR_W-1 -: dmc_pkg::TAG_W];
            res = '0;
            case (cmd)
                dmc_pkg::CMD_LOOKUP: begin
                    n_lookup++;
                    if (valid_mark[idx] && tag_store[idx] == tag) begin
                        res.hit  = 1'b1;
                        res.word = addr[2]
                                 ? data_store[idx][dmc_pkg::WORD_W +: dmc_pkg::WORD_W]
                                 : data_store[idx][0 +: dmc_pkg::WORD_W];
                        n_hit++;
                    end
                end
                dmc_pkg::CMD_WRITE: begin
                    // replace the low bytes, any tag; oversize means the whole line
                    n_write++;
                    nbytes = (size > dmc_pkg::BYTES) ? dmc_pkg::BYTES : size;
                    for (int b = 0; b < nbytes; b++)
                        data_store[idx][8*b +: 8] = wdata[8*b +: 8];
                end
                dmc_pkg::CMD_FILL: begin
                    n_fill++;
                    data_store[idx] = wdata;
                    tag_store[idx]  = tag;
                    valid_mark[idx] = 1'b1;
                end
                default: n_none++;
            endcase
            pending_access_results.push_back(res);
        endfunction

        function void check_response(logic hit, logic [dmc_pkg::WORD_W-1:0] word);
            access_result_t exp_res;
            if (pending_access_results.size() == 0) begin
                $error("result with nothing outstanding: hit %0b read_word %h", hit, word);
                errors++;
                return;
            end
            exp_res = pending_access_results.pop_front();
            n_checked++;
            if (hit !== exp_res.hit) begin
                $error("hit: expected %0b, got %0b", exp_res.hit, hit);
                errors++;
            end
            if (word !== exp_res.word) begin
                $error("read_word: expected %h, got %h", exp_res.word, word);
                errors++;
            end
        endfunction
    endclass

    localparam int HOT_LINES   = 8;
    localparam int HOT_TAGS    = 3;
    localparam int DRAIN_LIMIT = 5000;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [dmc_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic [1:0]                     s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [dmc_pkg::WORD_W-1:0]     m_tdata;
    logic [0:0]                     m_tuser;

    dcache_scoreboard sb = new();

    // idle and stall odds, percent, set per phase
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    // long receiver hold-off, counted down by the receiver process
    int hold_cycles   = 0;

    dmc_pkg::line_idx_t hot_line [HOT_LINES];
    dmc_pkg::line_tag_t hot_tag  [HOT_TAGS];

    direct_mapped_dcache DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: hold off while a long stall is pending, else stall at random.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_tready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // Check every result that leaves the block.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_response(m_tuser[0], m_tdata);
    end

    // Offer one request; idle first at random, then hold it until accepted.
    task automatic send_request(dmc_pkg::cmd_t cmd, logic [dmc_pkg::ADDR_W-1:0] addr,
                                logic [dmc_pkg::DATA_W-1:0] wdata,
                                logic [dmc_pkg::SIZE_W-1:0] size);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{dmc_pkg::PAD_W{1'b0}}, size, wdata, addr};
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        sb.predict_access(cmd, addr, wdata, size);
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic wait_for_drain();
        int guard;
        guard = 0;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending_access_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        if (guard >= DRAIN_LIMIT) begin
            $error("results still outstanding: %0d", sb.pending_access_results.size());
            sb.errors++;
        end
    endtask

    // Mostly a few hot lines and tags so fills turn into hits; the rest fully random.
    function automatic logic [dmc_pkg::ADDR_W-1:0] pick_addr();
        logic [dmc_pkg::ADDR_W-1:0] a;
        a = {$urandom, $urandom};
        if ($urandom_range(99) < 88) begin
            a[dmc_pkg::OFFS_W +: dmc_pkg::IDX_W]   = hot_line[$urandom_range(HOT_LINES-1)];
            a[dmc_pkg::ADDR_W-1 -: dmc_pkg::TAG_W] = hot_tag[$urandom_range(HOT_TAGS-1)];
        end
        return a;
    endfunction

    task automatic send_random(int count);
        repeat (count) begin
            dmc_pkg::cmd_t              cmd;
            int                         roll;
            logic [dmc_pkg::SIZE_W-1:0] size;
            roll = $urandom_range(99);
            if (roll < 50)      cmd = dmc_pkg::CMD_LOOKUP;
            else if (roll < 72) cmd = dmc_pkg::CMD_WRITE;
            else if (roll < 95) cmd = dmc_pkg::CMD_FILL;
            else                cmd = dmc_pkg::CMD_NONE;
            // mostly legal sizes; zero and oversize now and then
            if ($urandom_range(99) < 85)
                size = dmc_pkg::SIZE_W'($urandom_range(dmc_pkg::BYTES, 1));
            else
                size = dmc_pkg::SIZE_W'($urandom_range(15));
            send_request(cmd, pick_addr(), {$urandom, $urandom}, size);
        end
    endtask

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        hot_line[0] = '0;
        hot_line[1] = '1;
        for (int i = 2; i < HOT_LINES; i++) hot_line[i] = dmc_pkg::line_idx_t'($urandom);
        hot_tag[0] = '0;
        hot_tag[1] = '1;
        hot_tag[2] = dmc_pkg::line_tag_t'({$urandom, $urandom});

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: misses on empty lines, both word halves, tag mismatch,
        // several write sizes incl. zero and oversize, write under a foreign tag,
        // the unused command, refill with a new tag, write to an invalid line.
        send_request(dmc_pkg::CMD_LOOKUP, 64'h0, 64'h0, 4'd0);
        send_request(dmc_pkg::CMD_LOOKUP, '1, '1, 4'hF);
        send_request(dmc_pkg::CMD_FILL, 64'h0, 64'h0123_4567_89AB_CDEF, 4'd8);
        send_request(dmc_pkg::CMD_LOOKUP, 64'h0, 64'h0, 4'd1);
        send_request(dmc_pkg::CMD_LOOKUP, 64'h4, 64'h0, 4'd1);
        send_request(dmc_pkg::CMD_LOOKUP, 64'h4000, 64'h0, 4'd1);
        send_request(dmc_pkg::CMD_FILL, '1, '1, 4'd0);
        send_request(dmc_pkg::CMD_LOOKUP, '1, 64'h0, 4'd2);
        send_request(dmc_pkg::CMD_LOOKUP, ~64'h4, 64'h0, 4'd2);
        send_request(dmc_pkg::CMD_WRITE, 64'h0, '1, 4'd0);
        send_request(dmc_pkg::CMD_LOOKUP, 64'h0, 64'h0, 4'd3);
        send_request(dmc_pkg::CMD_WRITE, 64'h0, '1, 4'd1);
        send_request(dmc_pkg::CMD_LOOKUP, 64'h0, 64'h0, 4'd3);
        send_request(dmc_pkg::CMD_WRITE, 64'h4000, 64'hA5A5_5A5A_C3C3_3C3C, 4'd8);
        send_request(dmc_pkg::CMD_LOOKUP, 64'h4, 64'h0, 4'd4);
        send_request(dmc_pkg::CMD_WRITE, 64'h0, 64'h1122_3344_5566_7788, 4'd15);
        send_request(dmc_pkg::CMD_LOOKUP, 64'h0, 64'h0, 4'd5);
        send_request(dmc_pkg::CMD_NONE, 64'h0, '1, 4'd8);
        send_request(dmc_pkg::CMD_LOOKUP, 64'h4, 64'h0, 4'd6);
        send_request(dmc_pkg::CMD_WRITE, 64'h0, 64'hDEAD_BEEF_CAFE_F00D, 4'd4);
        send_request(dmc_pkg::CMD_LOOKUP, 64'h0, 64'h0, 4'd7);
        send_request(dmc_pkg::CMD_FILL, 64'h4000, 64'h0F0F_F0F0_1234_5678, 4'd8);
        send_request(dmc_pkg::CMD_LOOKUP, 64'h0, 64'h0, 4'd8);
        send_request(dmc_pkg::CMD_LOOKUP, 64'h4004, 64'h0, 4'd8);
        send_request(dmc_pkg::CMD_WRITE, 64'h28, '1, 4'd3);
        send_request(dmc_pkg::CMD_LOOKUP, 64'h28, 64'h0, 4'd9);
        wait_for_drain();

        // Back to back, with one long receiver hold-off that backs up the input.
        send_random(60);
        hold_cycles = 300;
        send_random(135);
        wait_for_drain();

        src_idle_pct  = 51;
        snk_stall_pct = 0;
        send_random(195);
        wait_for_drain();

        src_idle_pct  = 0;
        snk_stall_pct = 51;
        send_random(195);
        wait_for_drain();

        src_idle_pct  = 31;
        snk_stall_pct = 31;
        send_random(195);
        wait_for_drain();

        repeat (20) @(posedge aclk);
        $display("Covered %0d requests: %0d lookups (%0d hits), %0d writes, %0d fills, %0d no-ops",
                 sb.n_lookup + sb.n_write + sb.n_fill + sb.n_none,
                 sb.n_lookup, sb.n_hit, sb.n_write, sb.n_fill, sb.n_none);
        $display("Checked %0d results under four idle/stall mixes and one long hold-off",
                 sb.n_checked);
        if (sb.errors == 0 && sb.pending_access_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
